@@ hw/rtl/tvp_pkg.sv @@
// shared types and constants for the timed valve positioner
// no dependencies; used by tvp_core and timed_valve_positioner

package tvp_pkg;

    localparam int unsigned POS_W       = 7;
    localparam int unsigned REQ_W       = 8;
    localparam int unsigned STEP_W      = 16;
    localparam int unsigned HOMING_W    = 24;
    localparam int unsigned CFG_DATA_W  = 24;
    localparam int unsigned CFG_ADDR_W  = 1;
    localparam int unsigned IN_DATA_W   = 8;
    localparam int unsigned OUT_DATA_W  = 24;

    localparam logic [REQ_W-1:0]    MAX_REQUEST = 8'd130;
    localparam logic [POS_W-1:0]    FULL_OPEN   = 7'd100;

    localparam logic [STEP_W-1:0]   STEP_TICKS_RESET   = 16'd350;
    localparam logic [HOMING_W-1:0] HOMING_TICKS_RESET = 24'd35000;

    // register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] REG_STEP_TICKS   = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_HOMING_TICKS = 1'b1;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_SET    = 2'd1,
        CMD_RETURN = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        DIR_NONE = 2'b00,
        DIR_UP   = 2'b01,
        DIR_DOWN = 2'b10
    } dir_t;

    typedef struct packed {
        logic [POS_W-1:0] current_position;
        logic [POS_W-1:0] target_position;
        logic             drive_up;
        logic             drive_down;
        logic             resetting;
        logic             moving;
        logic             rejected;
    } result_t;

endpackage

@@ hw/rtl/tvp_core.sv @@
// positioner state, configuration registers and per-item next-state logic
// depends on tvp_pkg

module tvp_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [tvp_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [tvp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            item_en,
    input  logic [1:0]                      item_cmd,
    input  logic [tvp_pkg::REQ_W-1:0]       item_req,
    output tvp_pkg::result_t                result
);

    logic [tvp_pkg::STEP_W-1:0]   step_ticks_reg;
    logic [tvp_pkg::HOMING_W-1:0] homing_ticks_reg;

    logic                         homing_reg,  homing_next;
    logic [tvp_pkg::HOMING_W-1:0] hcount_reg,  hcount_next;
    logic [tvp_pkg::STEP_W-1:0]   scount_reg,  scount_next;
    logic [tvp_pkg::POS_W-1:0]    pos_reg,     pos_next;
    logic [tvp_pkg::POS_W-1:0]    goal_reg,    goal_next;
    tvp_pkg::dir_t                dir_reg,     dir_next;
    logic                         rflag_reg,   rflag_next;
    logic                         rejected;

    logic [tvp_pkg::HOMING_W:0]   hcount_inc;
    logic [tvp_pkg::STEP_W:0]     scount_inc;

    assign hcount_inc = {1'b0, hcount_reg} + 1'b1;
    assign scount_inc = {1'b0, scount_reg} + 1'b1;

    always_comb begin
        homing_next = homing_reg;
        hcount_next = hcount_reg;
        scount_next = scount_reg;
        pos_next    = pos_reg;
        goal_next   = goal_reg;
        dir_next    = dir_reg;
        rflag_next  = rflag_reg;
        rejected    = 1'b0;
        case (tvp_pkg::cmd_t'(item_cmd))
            tvp_pkg::CMD_TICK: begin
                if (homing_reg) begin
                    if (hcount_inc >= {1'b0, homing_ticks_reg}) begin
                        homing_next = 1'b0;
                        hcount_next = '0;
                        rflag_next  = 1'b0;
                        scount_next = '0;
                    end else begin
                        hcount_next = hcount_inc[tvp_pkg::HOMING_W-1:0];
                    end
                end else begin
                    // one step at the start of each interval
                    if (scount_reg == '0) begin
                        if (pos_reg < goal_reg) begin
                            dir_next = tvp_pkg::DIR_UP;
                            pos_next = pos_reg + 1'b1;
                        end else if (pos_reg > goal_reg) begin
                            dir_next = tvp_pkg::DIR_DOWN;
                            pos_next = pos_reg - 1'b1;
                        end else begin
                            dir_next   = tvp_pkg::DIR_NONE;
                            rflag_next = 1'b0;
                        end
                    end
                    if (scount_inc >= {1'b0, step_ticks_reg}) begin
                        scount_next = '0;
                    end else begin
                        scount_next = scount_inc[tvp_pkg::STEP_W-1:0];
                    end
                end
            end
            tvp_pkg::CMD_SET: begin
                if (item_req > tvp_pkg::MAX_REQUEST) begin
                    rejected = 1'b1;
                end else if (item_req > {1'b0, tvp_pkg::FULL_OPEN}) begin
                    goal_next = tvp_pkg::FULL_OPEN;
                end else begin
                    goal_next = item_req[tvp_pkg::POS_W-1:0];
                end
            end
            tvp_pkg::CMD_RETURN: begin
                goal_next  = '0;
                rflag_next = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        result.current_position = pos_next;
        result.target_position  = goal_next;
        result.drive_up         = !homing_next && (dir_next == tvp_pkg::DIR_UP);
        result.drive_down       = homing_next || (dir_next == tvp_pkg::DIR_DOWN);
        result.resetting        = rflag_next;
        result.moving           = (pos_next != goal_next);
        result.rejected         = rejected;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_ticks_reg   <= tvp_pkg::STEP_TICKS_RESET;
            homing_ticks_reg <= tvp_pkg::HOMING_TICKS_RESET;
        end else if (cfg_we) begin
            if (cfg_addr == tvp_pkg::REG_STEP_TICKS) begin
                step_ticks_reg <= cfg_wdata[tvp_pkg::STEP_W-1:0];
            end
            if (cfg_addr == tvp_pkg::REG_HOMING_TICKS) begin
                homing_ticks_reg <= cfg_wdata[tvp_pkg::HOMING_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            homing_reg <= 1'b1;
            hcount_reg <= '0;
            scount_reg <= '0;
            pos_reg    <= '0;
            goal_reg   <= '0;
            dir_reg    <= tvp_pkg::DIR_NONE;
            rflag_reg  <= 1'b1;
        end else if (item_en) begin
            homing_reg <= homing_next;
            hcount_reg <= hcount_next;
            scount_reg <= scount_next;
            pos_reg    <= pos_next;
            goal_reg   <= goal_next;
            dir_reg    <= dir_next;
            rflag_reg  <= rflag_next;
        end
    end

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (pos_reg <= tvp_pkg::FULL_OPEN) && (goal_reg <= tvp_pkg::FULL_OPEN))
        else $error("position or target out of range");

    a_one_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        item_en |=> (pos_reg == $past(pos_reg) || pos_reg == $past(pos_reg) + 7'd1
                     || pos_reg == $past(pos_reg) - 7'd1))
        else $error("position moved by more than one unit");

    a_idle_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !item_en |=> ($stable(pos_reg) && $stable(homing_reg) && $stable(scount_reg)))
        else $error("state changed without an item");

    a_homing_end: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(homing_reg) |-> (!rflag_reg && scount_reg == '0))
        else $error("homing ended without clearing flag and step counter");

endmodule

@@ hw/rtl/timed_valve_positioner.sv @@
// Timed valve positioner: input item register, positioner core, result register.
// One result item per input item; the input register and the result register
// are separated by the core's single level of next-state logic, so an item is
// taken every clock while the result side keeps up, and a stalled result holds
// the input register full with ready low until it drains. An accepted item is
// held first in the input register and then in the result register until it is
// taken. After reset the block homes for homing_ticks tick items, driving down,
// before any step is taken; configuration writes take effect at the next clock
// edge.
// depends on tvp_pkg and tvp_core

module timed_valve_positioner (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_we,
    input  logic [tvp_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [tvp_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // input items
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [tvp_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // [7:0] requested_position
    input  logic [1:0]                        s_axis_tuser,  // [1:0] command
    // result items
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [6:0] current_position, [13:7] target_position, [14] drive_up,
    // [15] drive_down, [16] resetting, [17] moving, [18] rejected, [23:19] zero
    output logic [tvp_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

    logic                          in_valid_reg;
    logic [1:0]                    in_cmd_reg;
    logic [tvp_pkg::REQ_W-1:0]     in_req_reg;
    logic                          out_valid_reg;
    tvp_pkg::result_t              out_res_reg;
    tvp_pkg::result_t              core_res;
    logic                          advance;

    // item moves from input register into the result register
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_cmd_reg <= s_axis_tuser;
            in_req_reg <= s_axis_tdata;
        end
    end

    tvp_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .item_en   (advance),
        .item_cmd  (in_cmd_reg),
        .item_req  (in_req_reg),
        .result    (core_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= core_res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0,
                            out_res_reg.rejected,
                            out_res_reg.moving,
                            out_res_reg.resetting,
                            out_res_reg.drive_down,
                            out_res_reg.drive_up,
                            out_res_reg.target_position,
                            out_res_reg.current_position};

endmodule

@@ dv/timed_valve_positioner_tb.sv @@
`timescale 1ns / 100ps
// self-checking testbench for the timed valve positioner: stream stimulus, a
// scoreboard class with its own positioner prediction, random idling on both sides
// depends on tvp_pkg and timed_valve_positioner

module timed_valve_positioner_tb;

    localparam logic [1:0]          CMD_UNUSED   = 2'd3;
    localparam int unsigned         QUIET_LIMIT  = 1000;
    localparam int unsigned         DRAIN_CYCLES = 4;
    localparam int unsigned         N_PHASES     = 10;
    localparam int unsigned         PHASE_ITEMS  = 135;
    localparam int unsigned         STEP_PICK    = 32'hFFFF_FFFF;
    localparam logic [tvp_pkg::HOMING_W-1:0] HOMING_MAX = 24'hFF_FFFF;
    localparam int unsigned PHASE_STEP [N_PHASES] =
        '{0, 1, 3, 65535, 2, 12, 1, 350, STEP_PICK, 5};

    typedef struct packed {
        logic [4:0]                pad;
        logic                      rejected;
        logic                      moving;
        logic                      resetting;
        logic                      drive_down;
        logic                      drive_up;
        logic [tvp_pkg::POS_W-1:0] target_position;
        logic [tvp_pkg::POS_W-1:0] current_position;
    } valve_result_t;

    typedef enum logic [1:0] {
        SINK_FREE,
        SINK_CHOPPY,
        SINK_BURSTY
    } sink_mode_t;

    class valve_scoreboard;
        logic [tvp_pkg::STEP_W-1:0]   step_lim;
        logic [tvp_pkg::HOMING_W-1:0] homing_lim;
        logic                         homing;
        logic [tvp_pkg::HOMING_W-1:0] homing_cnt;
        logic [tvp_pkg::STEP_W-1:0]   step_cnt;
        logic [tvp_pkg::POS_W-1:0]    pos_now;
        logic [tvp_pkg::POS_W-1:0]    pos_goal;
        tvp_pkg::dir_t                dir;
        logic                         busy_flag;
        valve_result_t                expected_q [$];
        int unsigned                  errors, shown, items, results, rejects, ups, downs;

        function new();
            step_lim   = tvp_pkg::STEP_TICKS_RESET;
            homing_lim = tvp_pkg::HOMING_TICKS_RESET;
            homing     = 1'b1;
            homing_cnt = '0;
            step_cnt   = '0;
            pos_now    = '0;
            pos_goal   = '0;
            dir        = tvp_pkg::DIR_NONE;
            busy_flag  = 1'b1;
            errors = 0; shown = 0; items = 0; results = 0;
            rejects = 0; ups = 0; downs = 0;
        endfunction

        function void flag(string msg);
            errors++;
            if (shown < 10) begin
                shown++;
                $display("%s", msg);
            end
        endfunction

        function void set_limit(logic [tvp_pkg::CFG_ADDR_W-1:0] idx,
                                logic [tvp_pkg::CFG_DATA_W-1:0] val);
            if (idx == tvp_pkg::REG_STEP_TICKS)
                step_lim = val[tvp_pkg::STEP_W-1:0];
            else if (idx == tvp_pkg::REG_HOMING_TICKS)
                homing_lim = val[tvp_pkg::HOMING_W-1:0];
        endfunction

        function void note_item(logic [1:0] cmd, logic [tvp_pkg::REQ_W-1:0] req);
            valve_result_t e;
            int unsigned   nxt, sc;
            e = '0;
            items++;
            case (cmd)
                tvp_pkg::CMD_TICK: begin
                    if (homing) begin
                        nxt = homing_cnt + 1;
                        if (nxt >= homing_lim) begin
                            homing     = 1'b0;
                            homing_cnt = '0;
                            busy_flag  = 1'b0;
                            step_cnt   = '0;
                        end else begin
                            homing_cnt = nxt[tvp_pkg::HOMING_W-1:0];
                        end
                    end else begin
                        if (step_cnt == 0) begin
                            if (pos_now < pos_goal) begin
                                dir = tvp_pkg::DIR_UP;
                                pos_now++;
                                ups++;
                            end else if (pos_now > pos_goal) begin
                                dir = tvp_pkg::DIR_DOWN;
                                pos_now--;
                                downs++;
                            end else begin
                                dir = tvp_pkg::DIR_NONE;
                                busy_flag = 1'b0;
                            end
                        end
                        // a lowered limit ends the interval on this tick
                        sc = step_cnt + 1;
                        if (sc >= step_lim)
                            sc = 0;
                        step_cnt = sc[tvp_pkg::STEP_W-1:0];
                    end
                end
                tvp_pkg::CMD_SET: begin
                    if (req > tvp_pkg::MAX_REQUEST) begin
                        e.rejected = 1'b1;
                        rejects++;
                    end else begin
                        pos_goal = (req > tvp_pkg::FULL_OPEN) ? tvp_pkg::FULL_OPEN
                                                              : req[tvp_pkg::POS_W-1:0];
                    end
                end
                tvp_pkg::CMD_RETURN: begin
                    pos_goal  = '0;
                    busy_flag = 1'b1;
                end
                default: ;
            endcase
            e.current_position = pos_now;
            e.target_position  = pos_goal;
            e.drive_up         = !homing && dir == tvp_pkg::DIR_UP;
            e.drive_down       = homing || dir == tvp_pkg::DIR_DOWN;
            e.resetting        = busy_flag;
            e.moving           = pos_now != pos_goal;
            expected_q.push_back(e);
        endfunction

        function void check_result(logic [tvp_pkg::OUT_DATA_W-1:0] data);
            valve_result_t e, g;
            results++;
            g.current_position = data[6:0];
            g.target_position  = data[13:7];
            g.drive_up         = data[14];
            g.drive_down       = data[15];
            g.resetting        = data[16];
            g.moving           = data[17];
            g.rejected         = data[18];
            g.pad              = data[23:19];
            if (expected_q.size() == 0) begin
                flag($sformatf("result %0d with nothing expected: tdata %h", results, data));
            end else begin
                e = expected_q.pop_front();
                if (g.current_position !== e.current_position ||
                    g.target_position  !== e.target_position  ||
                    g.drive_up         !== e.drive_up         ||
                    g.drive_down       !== e.drive_down       ||
                    g.resetting        !== e.resetting        ||
                    g.moving           !== e.moving           ||
                    g.rejected         !== e.rejected         ||
                    g.pad              !== e.pad)
                    flag($sformatf({"result %0d mismatch: expected pos %0d tgt %0d up %b ",
                        "down %b rst %b mov %b rej %b pad %h, got pos %0d tgt %0d up %b ",
                        "down %b rst %b mov %b rej %b pad %h"}, results,
                        e.current_position, e.target_position, e.drive_up, e.drive_down,
                        e.resetting, e.moving, e.rejected, e.pad,
                        g.current_position, g.target_position, g.drive_up, g.drive_down,
                        g.resetting, g.moving, g.rejected, g.pad));
            end
        endfunction

        function void flush_leftover();
            if (expected_q.size() != 0)
                flag($sformatf("%0d expected results never arrived", expected_q.size()));
        endfunction
    endclass

    logic                           aclk;
    logic                           aresetn;
    logic                           cfg_we;
    logic [tvp_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [tvp_pkg::CFG_DATA_W-1:0] cfg_wdata;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [tvp_pkg::IN_DATA_W-1:0]  s_axis_tdata;   // [7:0] requested_position
    logic [1:0]                     s_axis_tuser;   // [1:0] command
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    // [6:0] current_position, [13:7] target_position, [14] drive_up,
    // [15] drive_down, [16] resetting, [17] moving, [18] rejected, [23:19] zero
    logic [tvp_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    valve_scoreboard sb;
    int unsigned     burst_left;
    int unsigned     tick_run;

    timed_valve_positioner dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // results are checked before the new item is noted, so a result never
    // pairs with an item taken on the same edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_item(s_axis_tuser, s_axis_tdata);
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout after %0d quiet cycles", QUIET_LIMIT);
        $display("FAIL timed_valve_positioner");
        $finish;
    end

    initial begin : result_sink
        sink_mode_t  mode;
        int unsigned mode_left, stall_left;
        m_axis_tready = 1'b0;
        mode = SINK_FREE;
        mode_left = 0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (mode_left == 0) begin
                mode = sink_mode_t'($urandom_range(2));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                case (mode)
                    SINK_FREE:   m_axis_tready <= 1'b1;
                    SINK_CHOPPY: m_axis_tready <= ($urandom_range(3) != 0);
                    default: begin
                        if ($urandom_range(15) == 0) begin
                            stall_left = $urandom_range(5, 25);
                            m_axis_tready <= 1'b0;
                        end else begin
                            m_axis_tready <= 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(input logic [1:0] cmd, input logic [tvp_pkg::REQ_W-1:0] req);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(7) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 24);
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= req;
        s_axis_tuser  <= cmd;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [tvp_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [tvp_pkg::CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        sb.set_limit(idx, val);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        burst_left = 0;
    endtask

    // mostly ticks, with long tick runs now and then so the position can sweep
    task automatic pick_item(output logic [1:0] cmd,
                             output logic [tvp_pkg::REQ_W-1:0] req);
        int unsigned pick;
        req = 8'($urandom_range(255));
        if (tick_run > 0) begin
            tick_run--;
            cmd = tvp_pkg::CMD_TICK;
        end else begin
            pick = $urandom_range(99);
            if (pick < 3) begin
                tick_run = $urandom_range(40, 120);
                cmd = tvp_pkg::CMD_TICK;
            end else if (pick < 68) begin
                cmd = tvp_pkg::CMD_TICK;
            end else if (pick < 86) begin
                cmd = tvp_pkg::CMD_SET;
                pick = $urandom_range(99);
                if (pick < 55)
                    req = 8'($urandom_range(0, 100));
                else if (pick < 70)
                    req = 8'($urandom_range(101, 130));
                else if (pick < 85)
                    req = 8'($urandom_range(131, 255));
                else
                    case ($urandom_range(5))
                        0: req = 8'd0;
                        1: req = 8'd100;
                        2: req = 8'd101;
                        3: req = tvp_pkg::MAX_REQUEST;
                        4: req = 8'd131;
                        default: req = 8'd255;
                    endcase
            end else if (pick < 94) begin
                cmd = tvp_pkg::CMD_RETURN;
            end else begin
                cmd = CMD_UNUSED;
            end
        end
    endtask

    initial begin : main
        int unsigned                 ph, counted, step_val;
        logic [1:0]                  cmd;
        logic [tvp_pkg::REQ_W-1:0]   req;
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = tvp_pkg::REG_STEP_TICKS;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = tvp_pkg::CMD_TICK;
        burst_left    = 0;
        tick_run      = 0;
        sb = new();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // commands while homing with the reset-time homing length
        write_reg(tvp_pkg::REG_STEP_TICKS, 24'd1);
        send_item(tvp_pkg::CMD_TICK, 8'h00);
        send_item(tvp_pkg::CMD_SET, 8'd0);
        send_item(tvp_pkg::CMD_SET, 8'd100);
        send_item(tvp_pkg::CMD_SET, 8'd101);
        send_item(tvp_pkg::CMD_SET, tvp_pkg::MAX_REQUEST);
        send_item(tvp_pkg::CMD_SET, 8'd131);
        send_item(tvp_pkg::CMD_SET, 8'd255);
        send_item(tvp_pkg::CMD_TICK, 8'hFF);
        send_item(CMD_UNUSED, 8'hFF);
        send_item(tvp_pkg::CMD_RETURN, 8'h00);
        send_item(tvp_pkg::CMD_SET, 8'd3);
        send_item(tvp_pkg::CMD_TICK, 8'hAA);
        send_item(tvp_pkg::CMD_TICK, 8'h55);
        send_item(CMD_UNUSED, 8'h00);
        drain();

        // zero homing length written mid-count: homing ends on the next tick
        write_reg(tvp_pkg::REG_HOMING_TICKS, 24'd0);
        send_item(tvp_pkg::CMD_TICK, 8'h00);
        repeat (4) send_item(tvp_pkg::CMD_TICK, 8'h0F);
        send_item(tvp_pkg::CMD_SET, tvp_pkg::MAX_REQUEST);
        send_item(tvp_pkg::CMD_TICK, 8'hF0);
        send_item(tvp_pkg::CMD_RETURN, 8'hFF);
        repeat (5) send_item(tvp_pkg::CMD_TICK, 8'h00);
        drain();

        for (ph = 0; ph < N_PHASES; ph++) begin
            step_val = PHASE_STEP[ph];
            if (step_val == STEP_PICK)
                step_val = $urandom_range(1, 40);
            write_reg(tvp_pkg::REG_STEP_TICKS, step_val[tvp_pkg::CFG_DATA_W-1:0]);
            if (ph == 3)
                write_reg(tvp_pkg::REG_HOMING_TICKS, HOMING_MAX);
            if (ph == 7)
                write_reg(tvp_pkg::REG_HOMING_TICKS, 24'd1);
            counted = 0;
            tick_run = 0;
            while (counted < PHASE_ITEMS) begin
                pick_item(cmd, req);
                send_item(cmd, req);
                if (cmd != CMD_UNUSED)
                    counted++;
            end
            drain();
        end

        sb.flush_leftover();
        $display("ran %0d items and checked %0d results over %0d step settings",
                 sb.items, sb.results, N_PHASES + 1);
        $display("%0d set requests refused, %0d steps up and %0d steps down, %0d errors",
                 sb.rejects, sb.ups, sb.downs, sb.errors);
        if (sb.errors == 0)
            $display("PASS timed_valve_positioner");
        else
            $display("FAIL timed_valve_positioner");
        $finish;
    end

endmodule

@@ timed_valve_positioner.f @@
hw/rtl/tvp_pkg.sv
hw/rtl/tvp_core.sv
hw/rtl/timed_valve_positioner.sv
dv/timed_valve_positioner_tb.sv
